FILE: rtl/core/vgbs_pkg.sv
// Shared constants, command codes, control structs and helpers for the voxel grid box store.
package vgbs_pkg;

    localparam int MAX_DIM   = 16;
    localparam int ID_BITS   = 16;
    localparam int DIM_W     = 5;
    localparam int POS_W     = 4;
    localparam int SIZE_W    = 5;
    localparam int CMD_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CELLS     = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int TOT_W     = ADDR_W + 1;
    localparam int IDX_W     = ADDR_W + 2;
    localparam int WD_W      = $clog2(MAX_DIM * MAX_DIM) + 1;

    localparam logic [CMD_W-1:0] CMD_READ  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FILL  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_BCLR  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_OVL   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_FIND  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    typedef struct packed {
        logic latch;
        logic prep1;
        logic prep2;
        logic walk_step;
        logic scan_init;
        logic scan_step;
        logic mem_rd;
        logic mem_wr;
        logic wr_zero;
        logic chk;
        logic rd_cap;
        logic set_ok;
    } t_dp_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             in_range;
        logic             box_ok;
        logic             origin_ok;
        logic             walk_last;
        logic             scan_last;
        logic             clear_last;
    } t_dp_stat;

    // Zero acts as one, anything above the maximum acts as the maximum.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r);
        logic [DIM_W-1:0] res;
        if (r == '0) begin
            res = DIM_W'(1);
        end else if (r > DIM_W'(MAX_DIM)) begin
            res = DIM_W'(MAX_DIM);
        end else begin
            res = r;
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/vgbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module vgbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/vgbs_dp.sv
// Datapath: configuration registers, index arithmetic, box walker, cell store and result registers.
module vgbs_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [vgbs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [vgbs_pkg::DIM_W-1:0]      i_cfg_data,
    input  logic [vgbs_pkg::CMD_W-1:0]      i_cmd,
    input  logic [vgbs_pkg::POS_W-1:0]      i_pos_x,
    input  logic [vgbs_pkg::POS_W-1:0]      i_pos_y,
    input  logic [vgbs_pkg::POS_W-1:0]      i_pos_z,
    input  logic [vgbs_pkg::SIZE_W-1:0]     i_size_x,
    input  logic [vgbs_pkg::SIZE_W-1:0]     i_size_y,
    input  logic [vgbs_pkg::SIZE_W-1:0]     i_size_z,
    input  logic [vgbs_pkg::ID_BITS-1:0]    i_value,
    input  vgbs_pkg::t_dp_cmd               i_dp_cmd,
    output vgbs_pkg::t_dp_stat              o_stat,
    output logic [vgbs_pkg::ID_BITS-1:0]    o_read_value,
    output logic                            o_ok,
    output logic                            o_hit
);

    localparam int DW  = vgbs_pkg::DIM_W;
    localparam int SW  = vgbs_pkg::SIZE_W;
    localparam int PW  = vgbs_pkg::POS_W;
    localparam int XW  = vgbs_pkg::IDX_W;
    localparam int TW  = vgbs_pkg::TOT_W;
    localparam int WW  = vgbs_pkg::WD_W;
    localparam int AW  = vgbs_pkg::ADDR_W;
    localparam int IDW = vgbs_pkg::ID_BITS;

    // configuration
    logic [DW-1:0] r_cfg_w, r_cfg_d, r_cfg_h;

    // latched item
    logic [vgbs_pkg::CMD_W-1:0] r_cmd;
    logic [PW-1:0]  r_px, r_py, r_pz;
    logic [SW-1:0]  r_sx, r_sy, r_sz;
    logic [IDW-1:0] r_val;

    // derived geometry
    logic [DW-1:0] r_w, r_d, r_h;
    logic [WW-1:0] r_wd;
    logic [TW-1:0] r_total;
    logic [XW-1:0] r_base;

    // walker
    logic [XW-1:0] r_idx, r_row, r_plane;
    logic [SW-1:0] r_cx, r_cy, r_cz;

    // results
    logic [IDW-1:0] r_rd;
    logic           r_ok, r_hit, r_chk;

    logic [IDW-1:0] mem_rdata, mem_wdata;
    logic [XW-1:0]  n_base;
    logic           cx_end, cy_end, cz_end, unit_box, in_store, match;
    logic [PW+1:0]  end_x, end_y, end_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= DW'(vgbs_pkg::MAX_DIM);
            r_cfg_d <= DW'(vgbs_pkg::MAX_DIM);
            r_cfg_h <= DW'(vgbs_pkg::MAX_DIM);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vgbs_pkg::CFG_WIDTH:  r_cfg_w <= i_cfg_data;
                vgbs_pkg::CFG_DEPTH:  r_cfg_d <= i_cfg_data;
                vgbs_pkg::CFG_HEIGHT: r_cfg_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign n_base = XW'(r_px) + XW'(r_w) * XW'(r_py) + XW'(r_wd) * XW'(r_pz);

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.latch) begin
            r_cmd <= i_cmd;
            r_px  <= i_pos_x;
            r_py  <= i_pos_y;
            r_pz  <= i_pos_z;
            r_sx  <= i_size_x;
            r_sy  <= i_size_y;
            r_sz  <= i_size_z;
            r_val <= i_value;
        end
        if (i_dp_cmd.prep1) begin
            r_w  <= vgbs_pkg::eff_dim(r_cfg_w);
            r_d  <= vgbs_pkg::eff_dim(r_cfg_d);
            r_h  <= vgbs_pkg::eff_dim(r_cfg_h);
            r_wd <= WW'(vgbs_pkg::eff_dim(r_cfg_w)) * WW'(vgbs_pkg::eff_dim(r_cfg_d));
        end
        if (i_dp_cmd.prep2) begin
            r_total <= TW'(r_wd) * TW'(r_h);
            r_base  <= n_base;
        end
    end

    assign cx_end   = (r_cx == r_sx - SW'(1));
    assign cy_end   = (r_cy == r_sy - SW'(1));
    assign cz_end   = (r_cz == r_sz - SW'(1));
    assign unit_box = (r_sx == '0) || (r_sy == '0) || (r_sz == '0);
    assign in_store = (r_idx < XW'(r_total));

    // Walk x fastest; on a row wrap jump to the next row start, on a plane wrap to the next plane.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_dp_cmd.prep2) begin
            r_idx   <= n_base;
            r_row   <= n_base;
            r_plane <= n_base;
            r_cx    <= '0;
            r_cy    <= '0;
            r_cz    <= '0;
        end else if (i_dp_cmd.scan_init) begin
            r_idx <= '0;
        end else if (i_dp_cmd.scan_step) begin
            r_idx <= r_idx + XW'(1);
        end else if (i_dp_cmd.walk_step) begin
            if (!cx_end) begin
                r_cx  <= r_cx + SW'(1);
                r_idx <= r_idx + XW'(1);
            end else if (!cy_end) begin
                r_cx  <= '0;
                r_cy  <= r_cy + SW'(1);
                r_row <= r_row + XW'(r_w);
                r_idx <= r_row + XW'(r_w);
            end else begin
                r_cx    <= '0;
                r_cy    <= '0;
                r_cz    <= r_cz + SW'(1);
                r_plane <= r_plane + XW'(r_wd);
                r_row   <= r_plane + XW'(r_wd);
                r_idx   <= r_plane + XW'(r_wd);
            end
        end
    end

    assign mem_wdata = (i_dp_cmd.wr_zero) ? '0 :
                       ((r_cmd == vgbs_pkg::CMD_WRITE) || (r_cmd == vgbs_pkg::CMD_FILL)) ?
                       r_val : '0;

    vgbs_ram #(
        .WIDTH (IDW),
        .DEPTH (vgbs_pkg::CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_dp_cmd.mem_wr),
        .i_waddr (r_idx[AW-1:0]),
        .i_wdata (mem_wdata),
        .i_re    (i_dp_cmd.mem_rd),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    assign match = (r_cmd == vgbs_pkg::CMD_FIND) ? (mem_rdata == r_val) : (mem_rdata != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk <= 1'b0;
            r_ok  <= 1'b0;
            r_hit <= 1'b0;
            r_rd  <= '0;
        end else begin
            r_chk <= i_dp_cmd.chk && in_store;
            if (i_dp_cmd.latch) begin
                r_ok  <= 1'b0;
                r_hit <= 1'b0;
                r_rd  <= '0;
            end else begin
                if (i_dp_cmd.set_ok) begin
                    r_ok <= 1'b1;
                end
                if (r_chk && match) begin
                    r_hit <= 1'b1;
                end
                if (i_dp_cmd.rd_cap) begin
                    r_rd <= mem_rdata;
                end
            end
        end
    end

    // box end needs a bit beyond origin and extent so a large extent cannot wrap
    assign end_x = (PW+2)'(r_px) + (PW+2)'(r_sx);
    assign end_y = (PW+2)'(r_py) + (PW+2)'(r_sy);
    assign end_z = (PW+2)'(r_pz) + (PW+2)'(r_sz);

    always_comb begin
        o_stat.cmd        = r_cmd;
        o_stat.in_range   = ({1'b0, r_px} < r_w) && ({1'b0, r_py} < r_d) && ({1'b0, r_pz} < r_h);
        o_stat.box_ok     = !unit_box && (end_x <= (PW+2)'(r_w)) &&
                            (end_y <= (PW+2)'(r_d)) && (end_z <= (PW+2)'(r_h));
        o_stat.origin_ok  = (r_base < XW'(r_total));
        o_stat.walk_last  = unit_box || (cx_end && cy_end && cz_end);
        o_stat.scan_last  = (r_idx == XW'(r_total) - XW'(1));
        o_stat.clear_last = (r_idx[AW-1:0] == '1);
    end

    assign o_read_value = r_rd;
    assign o_ok         = r_ok;
    assign o_hit        = r_hit;

endmodule

FILE: rtl/core/vgbs_ctrl.sv
// Controller: sequences setup, point access, box walks, scans and clearing sweeps.
module vgbs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  vgbs_pkg::t_dp_stat i_stat,
    output vgbs_pkg::t_dp_cmd  o_dp_cmd,
    output logic               o_busy,
    output logic               o_valid
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PREP1 = 4'd1;
    localparam logic [3:0] S_PREP2 = 4'd2;
    localparam logic [3:0] S_DISP  = 4'd3;
    localparam logic [3:0] S_RDW   = 4'd4;
    localparam logic [3:0] S_FILL  = 4'd5;
    localparam logic [3:0] S_OVL   = 4'd6;
    localparam logic [3:0] S_FIND  = 4'd7;
    localparam logic [3:0] S_WAIT  = 4'd8;
    localparam logic [3:0] S_CLEAR = 4'd9;
    localparam logic [3:0] S_RESP  = 4'd10;

    logic [3:0] r_state, n_state;
    logic       r_report, n_report;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_report <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_report <= n_report;
        end
    end

    always_comb begin
        o_dp_cmd = '0;
        n_state  = r_state;
        n_report = r_report;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_dp_cmd.latch = 1'b1;
                    n_report       = 1'b1;
                    n_state        = S_PREP1;
                end
            end
            S_PREP1: begin
                o_dp_cmd.prep1 = 1'b1;
                n_state        = S_PREP2;
            end
            S_PREP2: begin
                o_dp_cmd.prep2 = 1'b1;
                n_state        = S_DISP;
            end
            S_DISP: begin
                unique case (i_stat.cmd)
                    vgbs_pkg::CMD_READ: begin
                        if (i_stat.in_range) begin
                            o_dp_cmd.mem_rd = 1'b1;
                            n_state         = S_RDW;
                        end else begin
                            n_state = S_RESP;
                        end
                    end
                    vgbs_pkg::CMD_WRITE: begin
                        if (i_stat.in_range) begin
                            o_dp_cmd.mem_wr = 1'b1;
                            o_dp_cmd.set_ok = 1'b1;
                        end
                        n_state = S_RESP;
                    end
                    vgbs_pkg::CMD_FILL, vgbs_pkg::CMD_BCLR: begin
                        n_state = i_stat.box_ok ? S_FILL : S_RESP;
                    end
                    vgbs_pkg::CMD_OVL: begin
                        n_state = i_stat.origin_ok ? S_OVL : S_RESP;
                    end
                    vgbs_pkg::CMD_FIND: begin
                        o_dp_cmd.scan_init = 1'b1;
                        n_state            = S_FIND;
                    end
                    vgbs_pkg::CMD_CLEAR: begin
                        o_dp_cmd.scan_init = 1'b1;
                        n_state            = S_CLEAR;
                    end
                    default: begin
                        n_state = S_RESP;
                    end
                endcase
            end
            S_RDW: begin
                o_dp_cmd.rd_cap = 1'b1;
                n_state         = S_RESP;
            end
            S_FILL: begin
                o_dp_cmd.mem_wr    = 1'b1;
                o_dp_cmd.walk_step = 1'b1;
                if (i_stat.walk_last) begin
                    o_dp_cmd.set_ok = 1'b1;
                    n_state         = S_RESP;
                end
            end
            S_OVL: begin
                o_dp_cmd.mem_rd    = 1'b1;
                o_dp_cmd.chk       = 1'b1;
                o_dp_cmd.walk_step = 1'b1;
                if (i_stat.walk_last) begin
                    n_state = S_WAIT;
                end
            end
            S_FIND: begin
                o_dp_cmd.mem_rd    = 1'b1;
                o_dp_cmd.chk       = 1'b1;
                o_dp_cmd.scan_step = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                // let the last read land in the hit flag
                n_state = S_RESP;
            end
            S_CLEAR: begin
                o_dp_cmd.mem_wr    = 1'b1;
                o_dp_cmd.wr_zero   = 1'b1;
                o_dp_cmd.scan_step = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = r_report ? S_RESP : S_IDLE;
                end
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_RESP);

endmodule

FILE: rtl/core/voxel_grid_box_store.sv
// From accept to o_valid each item passes PREP1, PREP2 and DISP; write, out-of-range or refused
// commands then answer, a read adds a capture state, box fill/clear walks the box volume, overlap
// walks it and waits (not if the origin is outside), find scans w*d*h cells and waits, clear all
// sweeps 4096 cells; one cell of the store RAM port per cycle sets the walk. A new item is accepted
// in the cycle after o_valid. After reset the block sweeps all 4096 cells to zero and holds busy high.
// The result strobe lasts one cycle and cannot be held off by the receiver.
module voxel_grid_box_store (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [vgbs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [vgbs_pkg::DIM_W-1:0]      i_cfg_data,
    input  logic                            start,
    output logic                            busy,
    input  logic [vgbs_pkg::CMD_W-1:0]      i_cmd,
    input  logic [vgbs_pkg::POS_W-1:0]      i_pos_x,
    input  logic [vgbs_pkg::POS_W-1:0]      i_pos_y,
    input  logic [vgbs_pkg::POS_W-1:0]      i_pos_z,
    input  logic [vgbs_pkg::SIZE_W-1:0]     i_size_x,
    input  logic [vgbs_pkg::SIZE_W-1:0]     i_size_y,
    input  logic [vgbs_pkg::SIZE_W-1:0]     i_size_z,
    input  logic [vgbs_pkg::ID_BITS-1:0]    i_value,
    output logic                            o_valid,
    output logic [vgbs_pkg::ID_BITS-1:0]    o_read_value,
    output logic                            o_ok,
    output logic                            o_hit
);

    vgbs_pkg::t_dp_cmd  dp_cmd;
    vgbs_pkg::t_dp_stat dp_stat;

    vgbs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_stat   (dp_stat),
        .o_dp_cmd (dp_cmd),
        .o_busy   (busy),
        .o_valid  (o_valid)
    );

    vgbs_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (i_cmd),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .i_size_x     (i_size_x),
        .i_size_y     (i_size_y),
        .i_size_z     (i_size_z),
        .i_value      (i_value),
        .i_dp_cmd     (dp_cmd),
        .o_stat       (dp_stat),
        .o_read_value (o_read_value),
        .o_ok         (o_ok),
        .o_hit        (o_hit)
    );

endmodule

FILE: rtl/core/vgbs_chk.sv
// Port-level checker for the voxel grid box store, bound to the top level.
module vgbs_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         o_valid,
    input logic [vgbs_pkg::ID_BITS-1:0] o_read_value,
    input logic                         o_ok,
    input logic                         o_hit
);

    // a result only appears while an item is in flight
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe while idle");

    // an accepted item holds the block and never answers in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid))
        else $error("accepted item did not hold the block");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // read data, ok and hit come from different commands
    a_result_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!(o_ok && o_hit) && ((o_read_value == '0) || (!o_ok && !o_hit))))
        else $error("result fields from more than one command");

endmodule

bind voxel_grid_box_store vgbs_chk u_chk (.*);
